>>> hw/rtl/ps2mt_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker package
// Shared types and constants for the packet tracker.
// ----------------------------------------------------------------------------
package ps2mt_pkg;

    localparam int unsigned PosWidth = 15;
    localparam int unsigned CfgIdxWidth = 2;

    // Header byte bit positions.
    localparam int unsigned HdrLeft = 0;
    localparam int unsigned HdrRight = 1;
    localparam int unsigned HdrAlwaysOne = 3;
    localparam int unsigned HdrXSign = 4;
    localparam int unsigned HdrYSign = 5;
    localparam int unsigned HdrXOvf = 6;
    localparam int unsigned HdrYOvf = 7;

    localparam logic [PosWidth-1:0] PosSat = '1;
    localparam logic [PosWidth-1:0] MaxXReset = 15'd1024;
    localparam logic [PosWidth-1:0] MaxYReset = 15'd768;

    typedef logic [PosWidth-1:0] t_pos;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_CLAMP_EN = 2'd0,
        CFG_MAX_X    = 2'd1,
        CFG_MAX_Y    = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        BYTE_HDR = 2'd0,
        BYTE_X   = 2'd1,
        BYTE_Y   = 2'd2
    } t_byte_idx;

endpackage

>>> hw/rtl/ps2_mouse_packet_tracker.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker
// Assembles three-byte mouse packets and tracks cursor position and buttons.
// ----------------------------------------------------------------------------
// One mouse byte is taken per clock cycle. A complete, valid packet gives one
// result item in the output register in the cycle after its third byte is
// taken; header and X bytes give no result. The only stall comes from the
// single output register: while a result waits to be taken, a header or X
// byte is still accepted, but a third byte is held off until the register
// frees. Headers with bit 3 clear are dropped to resynchronise the stream,
// and packets with an overflow bit set give no result and change nothing.
// Registers: 0 clamp enable, 1 maximum X, 2 maximum Y; writes to index 3
// are ignored. The configuration port never stalls.
module ps2_mouse_packet_tracker
    import ps2mt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CfgIdxWidth-1:0] i_cfg_index,
    input  logic [PosWidth-1:0]    i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [7:0]             i_data_byte,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [PosWidth-1:0]    o_pos_x,
    output logic [PosWidth-1:0]    o_pos_y,
    output logic                   o_moved,
    output logic                   o_left_press,
    output logic                   o_left_release,
    output logic                   o_right_press,
    output logic                   o_right_release
);

    // Configuration registers.
    logic r_clamp_en;
    t_pos r_max_x;
    t_pos r_max_y;

    // Packet assembly state.
    t_byte_idx  r_byte_idx, n_byte_idx;
    logic [7:0] r_hdr;
    logic [7:0] r_x_byte;
    t_pos       r_cursor_x, n_cursor_x;
    t_pos       r_cursor_y, n_cursor_y;
    logic [1:0] r_buttons;

    // Result register.
    logic       r_out_valid;
    t_pos       r_pos_x;
    t_pos       r_pos_y;
    logic       r_moved;
    logic [3:0] r_edges;

    logic                in_acc;
    logic                is_last;
    logic                pkt_ok;
    logic                moved;
    logic signed [9:0]   dx;
    logic signed [9:0]   dy;
    logic [1:0]          changed;
    t_pos                cap_x;
    t_pos                cap_y;

    function automatic t_pos f_advance(input t_pos cur, input logic signed [9:0] delta,
                                       input t_pos cap);
        logic signed [16:0] sum;
        t_pos               res;
        sum = $signed({2'b00, cur}) + $signed({{7{delta[9]}}, delta});
        if (sum[16]) begin
            res = '0;
        end else if (sum[15:0] > {1'b0, cap}) begin
            res = cap;
        end else begin
            res = sum[PosWidth-1:0];
        end
        return res;
    endfunction

    assign o_cfg_ready = 1'b1;

    // A third byte needs the output register; the others never do.
    assign is_last    = (r_byte_idx == BYTE_Y);
    assign o_in_ready = !(is_last && r_out_valid && !i_out_ready);
    assign in_acc     = i_in_valid && o_in_ready;

    assign pkt_ok = !(r_hdr[HdrXOvf] || r_hdr[HdrYOvf]);

    always_comb begin
        n_byte_idx = r_byte_idx;
        if (in_acc) begin
            unique case (r_byte_idx)
                BYTE_X: n_byte_idx = BYTE_Y;
                BYTE_Y: n_byte_idx = BYTE_HDR;
                default: n_byte_idx = i_data_byte[HdrAlwaysOne] ? BYTE_X : BYTE_HDR;
            endcase
        end
    end

    always_comb begin
        dx      = $signed({r_hdr[HdrXSign], r_hdr[HdrXSign], r_x_byte});
        dy      = -$signed({r_hdr[HdrYSign], r_hdr[HdrYSign], i_data_byte});
        moved   = (dx != 10'sd0) || (dy != 10'sd0);
        cap_x   = r_clamp_en ? r_max_x : PosSat;
        cap_y   = r_clamp_en ? r_max_y : PosSat;
        changed = r_hdr[HdrRight:HdrLeft] ^ r_buttons;
        n_cursor_x = moved ? f_advance(r_cursor_x, dx, cap_x) : r_cursor_x;
        n_cursor_y = moved ? f_advance(r_cursor_y, dy, cap_y) : r_cursor_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp_en <= 1'b1;
            r_max_x    <= MaxXReset;
            r_max_y    <= MaxYReset;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CLAMP_EN: r_clamp_en <= i_cfg_data[0];
                CFG_MAX_X:    r_max_x    <= i_cfg_data;
                CFG_MAX_Y:    r_max_y    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_idx  <= BYTE_HDR;
            r_hdr       <= '0;
            r_x_byte    <= '0;
            r_cursor_x  <= '0;
            r_cursor_y  <= '0;
            r_buttons   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_byte_idx <= n_byte_idx;
            // A new result may replace the one taken in the same cycle.
            if (in_acc && is_last && pkt_ok) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc) begin
                unique case (r_byte_idx)
                    BYTE_X: r_x_byte <= i_data_byte;
                    BYTE_Y: begin
                        if (pkt_ok) begin
                            r_cursor_x  <= n_cursor_x;
                            r_cursor_y  <= n_cursor_y;
                            r_buttons   <= r_hdr[HdrRight:HdrLeft];
                        end
                    end
                    default: r_hdr <= i_data_byte;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && is_last && pkt_ok) begin
            r_pos_x <= n_cursor_x;
            r_pos_y <= n_cursor_y;
            r_moved <= moved;
            r_edges <= {changed[1] & r_buttons[1], changed[1] & r_hdr[HdrRight],
                        changed[0] & r_buttons[0], changed[0] & r_hdr[HdrLeft]};
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pos_x         = r_pos_x;
    assign o_pos_y         = r_pos_y;
    assign o_moved         = r_moved;
    assign o_left_press    = r_edges[0];
    assign o_left_release  = r_edges[1];
    assign o_right_press   = r_edges[2];
    assign o_right_release = r_edges[3];

    a_idx_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_idx != 2'd3)
        else $error("byte index left the three-byte cycle");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_last && pkt_ok) |=> r_out_valid)
        else $error("valid packet gave no result item");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(in_acc && is_last && pkt_ok))
        else $error("result item appeared without a completed packet");

    a_press_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_edges[0] && r_edges[1]) && !(r_edges[2] && r_edges[3]))
        else $error("button pressed and released in one item");

endmodule
